[sv/lnbs_pkg.sv]
`timescale 1ns / 1ps

package lnbs_pkg;

  // Field widths of the channel payloads
  localparam int FUNC_W   = 3;
  localparam int LINE_W   = 16;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 3;

  // Default sizes of the line table and the return stack
  localparam int MAX_LINES_DEF   = 256;
  localparam int STACK_DEPTH_DEF = 16;

  // Command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 3'd0,
    FN_START  = 3'd1,
    FN_STEP   = 3'd2,
    FN_GOTO   = 3'd3,
    FN_IF     = 3'd4,
    FN_GOSUB  = 3'd5,
    FN_RETURN = 3'd6,
    FN_END    = 3'd7
  } func_t;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_GOSUB   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

endpackage

[sv/lnbs_in_if.sv]
`timescale 1ns / 1ps

interface lnbs_in_if
  import lnbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [LINE_W-1:0] line_value;
  logic              cond_true;

  modport source (output valid, func, line_value, cond_true, input ready);
  modport sink   (input valid, func, line_value, cond_true, output ready);
endinterface

[sv/lnbs_out_if.sv]
`timescale 1ns / 1ps

interface lnbs_out_if
  import lnbs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LINE_W-1:0]   current_line;
  logic [INDEX_W-1:0]  current_index;
  logic                running;
  logic [STATUS_W-1:0] status;

  modport source (output valid, current_line, current_index, running, status, input ready);
  modport sink   (input valid, current_line, current_index, running, status, output ready);
endinterface

[sv/lnbs_ram.sv]
`timescale 1ns / 1ps

module lnbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/line_number_branch_sequencer_unit.sv]
`timescale 1ns / 1ps
// Flow: load, start, step, end and ignored commands pass through EXEC, FETCH and RESULT before the out beat.
// GOTO, taken IF and GOSUB add a linear table search (SEARCH); a push adds PUSH_RD and PUSH_WR.
// RETURN adds the stack read states RET_RD and RET_LD plus the same search.
// Commands are handled one at a time; the next is taken once the previous result is loaded.
// Reset (synchronous, rst_n low) clears line count, index, stack depth, run flag and handshakes;
// RAM contents stay undefined and are only used below line count and stack depth.

module line_number_branch_sequencer_unit
  import lnbs_pkg::*;
#(
  parameter int MAX_LINES   = MAX_LINES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lnbs_in_if.sink     in_ch,
  lnbs_out_if.source  out_ch
);

  localparam int IW  = $clog2(MAX_LINES);
  localparam int CW  = $clog2(MAX_LINES + 1);
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_PUSH_RD,
    S_PUSH_WR,
    S_RET_RD,
    S_RET_LD,
    S_FETCH,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  func_t               func_r, func_nxt;
  logic [LINE_W-1:0]   value_r, value_nxt;
  logic                cond_r, cond_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       pi_r, pi_nxt;
  logic [SDW-1:0]      sd_r, sd_nxt;
  logic                run_r, run_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]       where_r, where_nxt;
  logic [LINE_W-1:0]   target_r, target_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0]   out_line_r, out_line_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic                out_running_r, out_running_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Line table RAM ports
  logic                line_we, line_re;
  logic [IW-1:0]       line_waddr, line_raddr;
  logic [LINE_W-1:0]   line_wdata, line_rdata;

  // Return stack RAM ports
  logic                stk_we, stk_re;
  logic [SAW-1:0]      stk_waddr, stk_raddr;
  logic [LINE_W-1:0]   stk_wdata, stk_rdata;

  logic [CW-1:0]       pi_inc;
  logic                has_next;
  logic                hit;

  lnbs_ram #(.WIDTH(LINE_W), .DEPTH(MAX_LINES)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  lnbs_ram #(.WIDTH(LINE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign pi_inc   = CW'(pi_r) + CW'(1);
  assign has_next = pi_inc < count_r;
  assign hit      = cmp_v_r && (line_rdata == target_r);

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.current_line  = out_line_r;
  assign out_ch.current_index = out_index_r;
  assign out_ch.running       = out_running_r;
  assign out_ch.status        = out_status_r;

  // Sequencer: decode, table search, stack access, final table read
  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    value_nxt       = value_r;
    cond_nxt        = cond_r;
    status_nxt      = status_r;
    count_nxt       = count_r;
    pi_nxt          = pi_r;
    sd_nxt          = sd_r;
    run_nxt         = run_r;
    idx_nxt         = idx_r;
    cmp_v_nxt       = cmp_v_r;
    cmp_idx_nxt     = cmp_idx_r;
    where_nxt       = where_r;
    target_nxt      = target_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_line_nxt    = out_line_r;
    out_index_nxt   = out_index_r;
    out_running_nxt = out_running_r;
    out_status_nxt  = out_status_r;

    line_we    = 1'b0;
    line_waddr = count_r[IW-1:0];
    line_wdata = value_r;
    line_re    = 1'b0;
    line_raddr = pi_r;
    stk_we     = 1'b0;
    stk_waddr  = sd_r[SAW-1:0];
    stk_wdata  = line_rdata;
    stk_re     = 1'b0;
    stk_raddr  = sd_r[SAW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt   = func_t'(in_ch.func);
          value_nxt  = in_ch.line_value;
          cond_nxt   = in_ch.cond_true;
          status_nxt = ST_OK;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt   = S_FETCH;
        target_nxt  = value_r;
        idx_nxt     = '0;
        cmp_v_nxt   = 1'b0;
        if (func_r != FN_LOAD && func_r != FN_START && !run_r) begin
          // flow command while stopped: ignored
          state_nxt = S_FETCH;
        end else begin
          unique case (func_r)
            FN_LOAD: begin
              if (count_r < CW'(MAX_LINES)) begin
                line_we   = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                status_nxt = ST_TABLE_FULL;
              end
            end
            FN_START: begin
              pi_nxt  = '0;
              sd_nxt  = '0;
              run_nxt = (count_r != '0);
            end
            FN_STEP: begin
              if (has_next) pi_nxt = pi_inc[IW-1:0];
              else          run_nxt = 1'b0;
            end
            FN_IF: begin
              if (cond_r) begin
                state_nxt = S_SEARCH;
              end else if (has_next) begin
                pi_nxt = pi_inc[IW-1:0];
              end else begin
                run_nxt = 1'b0;
              end
            end
            FN_GOTO, FN_GOSUB: begin
              state_nxt = S_SEARCH;
            end
            FN_RETURN: begin
              if (sd_r == '0) begin
                run_nxt    = 1'b0;
                status_nxt = ST_NO_GOSUB;
              end else begin
                sd_nxt    = sd_r - SDW'(1);
                state_nxt = S_RET_RD;
              end
            end
            FN_END: begin
              run_nxt = 1'b0;
            end
            default: begin
              state_nxt = S_FETCH;
            end
          endcase
        end
      end

      // Pop: read the saved line number at the new top
      S_RET_RD: begin
        stk_re    = 1'b1;
        state_nxt = S_RET_LD;
      end

      S_RET_LD: begin
        target_nxt = stk_rdata;
        idx_nxt    = '0;
        cmp_v_nxt  = 1'b0;
        state_nxt  = S_SEARCH;
      end

      // Linear search: issue one read a cycle, compare the previous one
      S_SEARCH: begin
        if (hit) begin
          state_nxt = S_FETCH;
          if (func_r == FN_GOSUB && has_next) begin
            if (sd_r >= SDW'(STACK_DEPTH)) begin
              run_nxt    = 1'b0;
              status_nxt = ST_STACK_FULL;
            end else begin
              where_nxt = cmp_idx_r;
              state_nxt = S_PUSH_RD;
            end
          end else begin
            pi_nxt = cmp_idx_r;
          end
        end else if (idx_r < count_r) begin
          line_re     = 1'b1;
          line_raddr  = idx_r[IW-1:0];
          idx_nxt     = idx_r + CW'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[IW-1:0];
        end else begin
          state_nxt = S_FETCH;
          if (func_r == FN_RETURN) begin
            pi_nxt = '0;
          end else begin
            run_nxt    = 1'b0;
            status_nxt = ST_MISSING;
          end
        end
      end

      // Push the line number that follows the GOSUB
      S_PUSH_RD: begin
        line_re    = 1'b1;
        line_raddr = pi_inc[IW-1:0];
        state_nxt  = S_PUSH_WR;
      end

      S_PUSH_WR: begin
        stk_we    = 1'b1;
        sd_nxt    = sd_r + SDW'(1);
        pi_nxt    = where_r;
        state_nxt = S_FETCH;
      end

      S_FETCH: begin
        line_re    = 1'b1;
        line_raddr = pi_r;
        state_nxt  = S_RESULT;
      end

      // Load the out register once it is free
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_line_nxt    = (count_r == '0) ? '0 : line_rdata;
          out_index_nxt   = INDEX_W'(pi_r);
          out_running_nxt = run_r;
          out_status_nxt  = status_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pi_r        <= '0;
      sd_r        <= '0;
      run_r       <= 1'b0;
      idx_r       <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pi_r        <= pi_nxt;
      sd_r        <= sd_nxt;
      run_r       <= run_nxt;
      idx_r       <= idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r        <= func_nxt;
    value_r       <= value_nxt;
    cond_r        <= cond_nxt;
    status_r      <= status_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    where_r       <= where_nxt;
    target_r      <= target_nxt;
    out_line_r    <= out_line_nxt;
    out_index_r   <= out_index_nxt;
    out_running_r <= out_running_nxt;
    out_status_r  <= out_status_nxt;
  end

endmodule

[bench/line_number_branch_sequencer_unit_tb.sv]
`timescale 1ns / 1ps

module line_number_branch_sequencer_unit_tb;
  import lnbs_pkg::*;

  localparam int MAX_LINES   = MAX_LINES_DEF;
  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int RAND_CMDS   = 1850;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = MAX_LINES + 16;
  localparam int DIR_ROWS    = 30;
  localparam int MAX_PRINTS  = 100;

  // One out beat as the block reports it
  typedef struct packed {
    logic [LINE_W-1:0]   line;
    logic [INDEX_W-1:0]  index;
    logic                running;
    logic [STATUS_W-1:0] status;
  } flow_beat_t;

  // Directed row: command plus an optional hand-written result
  typedef struct {
    func_t             func;
    logic [LINE_W-1:0] value;
    logic              cond;
    bit                typed;
    flow_beat_t        want;
  } dir_row_t;

  localparam flow_beat_t ANY_BEAT = '0;

  logic clk = 1'b0;
  logic rst_n;

  lnbs_in_if  in_ch ();
  lnbs_out_if out_ch ();

  line_number_branch_sequencer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Shadow state of the sequencer
  logic [LINE_W-1:0] line_mem [MAX_LINES];
  logic [LINE_W-1:0] ret_mem  [STACK_DEPTH];
  int line_cnt   = 0;
  int pc         = 0;
  int ret_depth  = 0;
  bit run_on     = 1'b0;

  flow_beat_t expected_flow [$];
  int err_cnt     = 0;
  int idle_cycles = 0;
  bit no_idle     = 1'b0;
  int burst_left  = 0;

  dir_row_t dir_tab [DIR_ROWS];

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("mismatch: %s got %0h want %0h at %0t", field, got, want, $realtime);
  endtask

  // First-match linear search of the loaded lines
  function automatic bit find_line(input logic [LINE_W-1:0] tgt, output int where);
    where = 0;
    for (int i = 0; i < line_cnt; i++) begin
      if (line_mem[i] == tgt) begin
        where = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void step_line();
    if (pc + 1 < line_cnt) pc = pc + 1;
    else run_on = 1'b0;
  endfunction

  function automatic void jump_line(input logic [LINE_W-1:0] tgt,
                                    inout logic [STATUS_W-1:0] st);
    int where;
    if (find_line(tgt, where)) begin
      pc = where;
    end else begin
      run_on = 1'b0;
      st = ST_MISSING;
    end
  endfunction

  // Apply one command to the shadow state and return the beat it causes
  function automatic flow_beat_t predict_flow(input func_t f, input logic [LINE_W-1:0] v,
                                              input logic c);
    logic [STATUS_W-1:0] st;
    int where;
    flow_beat_t res;
    st = ST_OK;
    if (f == FN_LOAD) begin
      if (line_cnt < MAX_LINES) begin
        line_mem[line_cnt] = v;
        line_cnt++;
      end else begin
        st = ST_TABLE_FULL;
      end
    end else if (f == FN_START) begin
      pc = 0;
      ret_depth = 0;
      run_on = line_cnt > 0;
    end else if (run_on) begin
      case (f)
        FN_STEP: step_line();
        FN_GOTO: jump_line(v, st);
        FN_IF: begin
          if (c) jump_line(v, st);
          else step_line();
        end
        FN_GOSUB: begin
          if (!find_line(v, where)) begin
            run_on = 1'b0;
            st = ST_MISSING;
          end else if (pc + 1 < line_cnt) begin
            if (ret_depth >= STACK_DEPTH) begin
              run_on = 1'b0;
              st = ST_STACK_FULL;
            end else begin
              ret_mem[ret_depth] = line_mem[pc + 1];
              ret_depth++;
              pc = where;
            end
          end else begin
            // last line: nothing to come back to
            pc = where;
          end
        end
        FN_RETURN: begin
          if (ret_depth == 0) begin
            run_on = 1'b0;
            st = ST_NO_GOSUB;
          end else begin
            ret_depth--;
            if (!find_line(ret_mem[ret_depth], where)) where = 0;
            pc = where;
          end
        end
        default: run_on = 1'b0;
      endcase
    end
    res.line    = (pc < line_cnt) ? line_mem[pc] : '0;
    res.index   = pc[INDEX_W-1:0];
    res.running = run_on;
    res.status  = st;
    return res;
  endfunction

  // Drive one command after a random gap and queue its result
  task automatic issue_cmd(input func_t f, input logic [LINE_W-1:0] v, input logic c,
                           input bit typed, input flow_beat_t want);
    int gap;
    flow_beat_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.line_value <= v;
    in_ch.cond_true  <= c;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_flow(f, v, c);
    expected_flow.push_back(typed ? want : pred);
  endtask

  // Mostly well-formed flow with targets from the table, plus noise
  task automatic pick_cmd(output func_t f, output logic [LINE_W-1:0] v, output logic c);
    int r;
    bit burst_pick;
    f = FN_STEP;
    v = LINE_W'($urandom);
    c = 1'($urandom_range(0, 1));
    burst_pick = 1'b0;
    if (!run_on) begin
      burst_left = 0;
      r = $urandom_range(0, 99);
      if (r < 70) f = FN_START;
      else if (r < ((line_cnt < MAX_LINES) ? 90 : 75)) f = FN_LOAD;
      else f = func_t'($urandom_range(2, 7));
    end else if (burst_left > 0) begin
      // nested calls to line 0 until the return stack overflows
      f = FN_GOSUB;
      v = line_mem[0];
      burst_pick = 1'b1;
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < ((line_cnt < MAX_LINES) ? 25 : 4)) begin
        f = FN_LOAD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 28) f = FN_STEP;
        else if (r < 42) f = FN_GOTO;
        else if (r < 62) f = FN_IF;
        else if (r < 79) f = FN_GOSUB;
        else if (r < 96) f = (ret_depth == 0 && $urandom_range(0, 3) != 0) ? FN_STEP : FN_RETURN;
        else if (r < 98) f = FN_END;
        else begin
          f = FN_GOSUB;
          v = line_mem[0];
          burst_pick = 1'b1;
          burst_left = STACK_DEPTH;
        end
      end
    end
    if (!burst_pick && line_cnt > 0) begin
      if ((f == FN_GOTO || f == FN_IF || f == FN_GOSUB) && $urandom_range(0, 99) < 85)
        v = line_mem[$urandom_range(0, line_cnt - 1)];
      else if (f == FN_LOAD && $urandom_range(0, 99) < 20)
        v = line_mem[$urandom_range(0, line_cnt - 1)];
    end
  endtask

  // Hold the sender until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_flow.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, compare each beat with the oldest expectation
  initial begin
    int stall;
    flow_beat_t got;
    flow_beat_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.current_line, out_ch.current_index, out_ch.running, out_ch.status};
      if (expected_flow.size() == 0) begin
        report_mismatch("unexpected beat, current_line", 32'(got.line), 0);
      end else begin
        want = expected_flow.pop_front();
        if (got.line !== want.line)
          report_mismatch("current_line", 32'(got.line), 32'(want.line));
        if (got.index !== want.index)
          report_mismatch("current_index", 32'(got.index), 32'(want.index));
        if (got.running !== want.running)
          report_mismatch("running", 32'(got.running), 32'(want.running));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Command side: reset, directed table, random flow, drain
  initial begin
    func_t f;
    logic [LINE_W-1:0] v;
    logic c;
    in_ch.valid      = 1'b0;
    in_ch.func       = FN_LOAD;
    in_ch.line_value = '0;
    in_ch.cond_true  = 1'b0;
    rst_n            = 1'b0;

    // Table after the loads: 0, FFFF, 100, 200, 100, 300
    dir_tab = '{
      '{FN_STEP,   16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_OK}},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_OK}},
      '{FN_LOAD,   16'h0000,  1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_OK}},
      '{FN_LOAD,   16'hFFFF,  1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_OK}},
      '{FN_LOAD,   16'd100,   1'b0, 1'b0, ANY_BEAT},
      '{FN_LOAD,   16'd200,   1'b0, 1'b0, ANY_BEAT},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b1, ST_OK}},
      '{FN_LOAD,   16'd100,   1'b1, 1'b0, ANY_BEAT},
      '{FN_LOAD,   16'd300,   1'b0, 1'b0, ANY_BEAT},
      '{FN_STEP,   16'hFFFF,  1'b1, 1'b1, '{16'hFFFF, 8'd1, 1'b1, ST_OK}},
      '{FN_GOTO,   16'hFFFF,  1'b0, 1'b0, ANY_BEAT},
      '{FN_GOTO,   16'd100,   1'b0, 1'b0, ANY_BEAT},
      '{FN_IF,     16'd0,     1'b0, 1'b0, ANY_BEAT},
      '{FN_IF,     16'd0,     1'b1, 1'b0, ANY_BEAT},
      '{FN_GOSUB,  16'd300,   1'b0, 1'b0, ANY_BEAT},
      '{FN_GOSUB,  16'd300,   1'b0, 1'b0, ANY_BEAT},
      '{FN_RETURN, 16'd0,     1'b0, 1'b0, ANY_BEAT},
      '{FN_RETURN, 16'd0,     1'b0, 1'b1, '{16'hFFFF, 8'd1, 1'b0, ST_NO_GOSUB}},
      '{FN_GOTO,   16'd200,   1'b0, 1'b1, '{16'hFFFF, 8'd1, 1'b0, ST_OK}},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b1, ST_OK}},
      '{FN_GOTO,   16'd12345, 1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_MISSING}},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b1, ST_OK}},
      '{FN_IF,     16'd555,   1'b1, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_MISSING}},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b1, ST_OK}},
      '{FN_GOSUB,  16'd777,   1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_MISSING}},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b1, ST_OK}},
      '{FN_GOTO,   16'd300,   1'b0, 1'b0, ANY_BEAT},
      '{FN_STEP,   16'd0,     1'b0, 1'b0, ANY_BEAT},
      '{FN_START,  16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b1, ST_OK}},
      '{FN_END,    16'd0,     1'b0, 1'b1, '{16'h0000, 8'd0, 1'b0, ST_OK}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (dir_tab[i])
      issue_cmd(dir_tab[i].func, dir_tab[i].value, dir_tab[i].cond,
                dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    // Random part, with idle-free stretches and periodic drains
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (n % 400 == 399) drain_results();
      pick_cmd(f, v, c);
      issue_cmd(f, v, c, 1'b0, ANY_BEAT);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
